// ===== hdl/rbs_pkg.sv =====
package rbs_pkg;

    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned MONO_W      = 63;
    localparam int unsigned RTIME_W     = 40;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned BACKOFF_W   = 16;
    localparam int unsigned MAXSTRK_W   = 8;
    localparam int unsigned ACTION_W    = 2;
    localparam int unsigned DELAY_W     = 9;
    localparam int unsigned STREAK_W    = 9;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned SHIFT_W     = 3;
    localparam int unsigned SHIFTED_W   = BACKOFF_W + 6;

    localparam logic [DELAY_W-1:0]   CAP_S           = 9'd300;
    localparam logic [MONO_W-1:0]    STREAK_RESET_US = 63'd300000000;
    localparam logic [SHIFT_W-1:0]   SHIFT_LIMIT     = 3'd6;
    localparam logic [STREAK_W-1:0]  STREAK_MAX      = 9'd511;
    localparam logic [COUNT_W-1:0]   COUNT_MAX       = 16'hFFFF;

    localparam logic [MODE_W-1:0]    MODE_RESET      = 2'd1;
    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET   = 16'd5;
    localparam logic [MAXSTRK_W-1:0] MAXSTRK_RESET   = 8'd10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_EXIT  = 2'd2,
        FUNC_PAUSE = 2'd3
    } func_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_GAVE_UP = 2'd2
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NEVER   = 2'd0,
        MODE_FAILURE = 2'd1,
        MODE_ALWAYS  = 2'd2
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RESTART_MODE = 2'd0,
        REG_BASE_BACKOFF = 2'd1,
        REG_MAX_STREAK   = 2'd2
    } cfg_reg_t;

endpackage

// ===== hdl/restart_backoff_supervisor_unit.sv =====
// Restart supervisor with truncated exponential backoff. Each event transaction
// (start attempt, stop request, process exit, pause notice) yields exactly one
// result transaction. Throughput is one transaction per clock while the result
// port does not stall; a transaction passes through the input register and then
// the result register before it appears on the result port. While the result
// port stalls, one further event is held in the input register. Configuration
// writes take effect at once and must only be made while no transaction is in
// flight.
module restart_backoff_supervisor_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rbs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          evt_valid,
    output logic                          evt_ready,
    input  logic [rbs_pkg::FUNC_W-1:0]    func,
    input  logic                          start_ok,
    input  logic                          clean,
    input  logic [rbs_pkg::MONO_W-1:0]    mono_time_us,
    input  logic [rbs_pkg::RTIME_W-1:0]   real_time_s,
    input  logic [rbs_pkg::RTIME_W-1:0]   pause_reset_s,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [rbs_pkg::ACTION_W-1:0]  action,
    output logic [rbs_pkg::DELAY_W-1:0]   delay_s,
    output logic [rbs_pkg::STREAK_W-1:0]  streak,
    output logic [rbs_pkg::COUNT_W-1:0]   restart_total,
    output logic                          paused
);
    import rbs_pkg::*;

    // configuration
    logic [MODE_W-1:0]    mode_reg;
    logic [BACKOFF_W-1:0] backoff_reg;
    logic [MAXSTRK_W-1:0] max_streak_reg;

    // supervisor state
    logic                 stopping_reg, stopping_next;
    logic [MONO_W-1:0]    stamp_reg, stamp_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [STREAK_W-1:0]  streak_reg, streak_next;
    logic [RTIME_W-1:0]   deadline_reg, deadline_next;

    // input register
    logic                 s1_valid_reg;
    func_t                s1_func_reg;
    logic                 s1_start_ok_reg;
    logic                 s1_clean_reg;
    logic [MONO_W-1:0]    s1_mono_reg;
    logic [RTIME_W-1:0]   s1_now_reg;
    logic [RTIME_W-1:0]   s1_pause_reg;

    // result register
    logic                 res_valid_reg;
    action_t              action_reg, action_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [STREAK_W-1:0]  res_streak_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    logic                 res_paused_reg, res_paused_next;

    logic                 evt_take;
    logic                 s1_advance;

    logic                 paused_pre;
    logic                 restart;
    logic                 uptime_long;
    logic [MONO_W-1:0]    uptime;
    logic [STREAK_W-1:0]  streak_a;
    logic [STREAK_W-1:0]  streak_b;
    logic                 give_up;
    logic [SHIFT_W-1:0]   sh;
    logic [BACKOFF_W-1:0] base_eff;
    logic [SHIFTED_W-1:0] shifted;
    logic [DELAY_W-1:0]   delay_cap;
    logic [RTIME_W-1:0]   wait_s;
    logic [DELAY_W-1:0]   wait_cap;

    assign s1_advance = s1_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready  = !s1_valid_reg || s1_advance;
    assign evt_take   = evt_valid && evt_ready;

    assign res_valid     = res_valid_reg;
    assign action        = action_reg;
    assign delay_s       = delay_reg;
    assign streak        = res_streak_reg;
    assign restart_total = res_count_reg;
    assign paused        = res_paused_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RESET;
            backoff_reg    <= BACKOFF_RESET;
            max_streak_reg <= MAXSTRK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RESTART_MODE: mode_reg       <= cfg_wdata[MODE_W-1:0];
                REG_BASE_BACKOFF: backoff_reg    <= cfg_wdata[BACKOFF_W-1:0];
                REG_MAX_STREAK:   max_streak_reg <= cfg_wdata[MAXSTRK_W-1:0];
                default:          ;
            endcase
        end
    end

    // event datapath
    always_comb
    begin
        paused_pre = (deadline_reg != '0) && (s1_now_reg < deadline_reg);

        case (mode_reg)
            MODE_ALWAYS:  restart = 1'b1;
            MODE_FAILURE: restart = !s1_clean_reg;
            default:      restart = 1'b0;
        endcase

        uptime      = s1_mono_reg - stamp_reg;
        uptime_long = (stamp_reg != '0) && (s1_mono_reg > stamp_reg)
                      && (uptime > STREAK_RESET_US);
        streak_a    = uptime_long ? '0 : streak_reg;

        if (s1_clean_reg)
            streak_b = '0;
        else if (!paused_pre && streak_a < STREAK_MAX)
            streak_b = streak_a + 1'b1;
        else
            streak_b = streak_a;

        give_up = (max_streak_reg != '0)
                  && (streak_b > {{(STREAK_W-MAXSTRK_W){1'b0}}, max_streak_reg});

        sh       = (streak_b < {{(STREAK_W-SHIFT_W){1'b0}}, SHIFT_LIMIT})
                   ? streak_b[SHIFT_W-1:0] : SHIFT_LIMIT;
        base_eff = (backoff_reg != '0) ? backoff_reg : {{(BACKOFF_W-1){1'b0}}, 1'b1};
        shifted  = {{(SHIFTED_W-BACKOFF_W){1'b0}}, base_eff} << sh;
        delay_cap = (shifted > {{(SHIFTED_W-DELAY_W){1'b0}}, CAP_S})
                    ? CAP_S : shifted[DELAY_W-1:0];

        wait_s   = deadline_reg - s1_now_reg;
        wait_cap = (wait_s > {{(RTIME_W-DELAY_W){1'b0}}, CAP_S})
                   ? CAP_S : wait_s[DELAY_W-1:0];

        stopping_next = stopping_reg;
        stamp_next    = stamp_reg;
        count_next    = count_reg;
        streak_next   = streak_reg;
        deadline_next = deadline_reg;
        action_next   = ACT_NONE;
        delay_next    = '0;

        case (s1_func_reg)
            FUNC_START:
            begin
                stopping_next = 1'b0;
                if (s1_start_ok_reg)
                begin
                    if (stamp_reg != '0 && count_reg < COUNT_MAX)
                        count_next = count_reg + 1'b1;
                    stamp_next = s1_mono_reg;
                end
            end
            FUNC_STOP:
                stopping_next = 1'b1;
            FUNC_PAUSE:
                deadline_next = s1_pause_reg;
            FUNC_EXIT:
            begin
                if (!stopping_reg && restart)
                begin
                    streak_next = streak_b;
                    if (give_up)
                        action_next = ACT_GAVE_UP;
                    else
                    begin
                        action_next = ACT_RESTART;
                        // a pending pause stretches the delay
                        delay_next  = (paused_pre && wait_cap > delay_cap) ? wait_cap : delay_cap;
                    end
                end
            end
            default: ;
        endcase

        res_paused_next = (deadline_next != '0) && (s1_now_reg < deadline_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            stopping_reg  <= 1'b0;
            stamp_reg     <= '0;
            count_reg     <= '0;
            streak_reg    <= '0;
            deadline_reg  <= '0;
        end
        else
        begin
            if (evt_take)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;

            if (s1_advance)
            begin
                stopping_reg <= stopping_next;
                stamp_reg    <= stamp_next;
                count_reg    <= count_next;
                streak_reg   <= streak_next;
                deadline_reg <= deadline_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            s1_func_reg     <= func_t'(func);
            s1_start_ok_reg <= start_ok;
            s1_clean_reg    <= clean;
            s1_mono_reg     <= mono_time_us;
            s1_now_reg      <= real_time_s;
            s1_pause_reg    <= pause_reset_s;
        end
        if (s1_advance)
        begin
            action_reg     <= action_next;
            delay_reg      <= delay_next;
            res_streak_reg <= streak_next;
            res_count_reg  <= count_next;
            res_paused_reg <= res_paused_next;
        end
    end

`ifndef SYNTHESIS
    a_delay_only_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (action_reg == ACT_RESTART) || (delay_reg == '0))
        else $error("delay reported without a restart");

    a_restart_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && action_reg == ACT_RESTART)
        |-> (delay_reg != '0) && (delay_reg <= CAP_S))
        else $error("restart delay out of range");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("restart count went backwards");

    a_gave_up_needs_streak: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && action_reg == ACT_GAVE_UP) |-> (res_streak_reg != '0))
        else $error("gave up with an empty failure streak");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && !res_ready) |-> !evt_ready)
        else $error("event taken while both registers are full");
`endif

endmodule
